// ===== src/pghs_pkg.sv =====
package pghs_pkg;

  localparam int GRID_SIDE_DEF = 10;

  localparam int POS_W      = 16;
  localparam int COUNT_W    = 16;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 46;
  localparam int ZZ_W       = 32;
  localparam int CFG_W      = 5;
  localparam int LEVEL_W    = 8;
  localparam int CELL_NUM_W = 7;
  localparam int KIND_W     = 2;
  // 255 * (count - min) fits in 24 bits
  localparam int NUM_W      = 24;

  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD       = 2'd0,
    KIND_SUMMARIZE = 2'd1,
    KIND_READ      = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_LVL,
    ST_DIV,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   hsum;
    logic [SQ_W-1:0]    sqsum;
  } cell_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [COUNT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== src/pghs_in_if.sv =====
interface pghs_in_if;
  import pghs_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [KIND_W-1:0]            kind;
  logic signed [POS_W-1:0]      x_pos;
  logic signed [POS_W-1:0]      y_pos;
  logic signed [POS_W-1:0]      z_pos;
  logic [CELL_NUM_W-1:0]        read_cell;

  modport source (
    output valid, kind, x_pos, y_pos, z_pos, read_cell,
    input  ready
  );

  modport sink (
    input  valid, kind, x_pos, y_pos, z_pos, read_cell,
    output ready
  );

endinterface

// ===== src/pghs_out_if.sv =====
interface pghs_out_if;
  import pghs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       in_grid;
  logic [CELL_NUM_W-1:0]      cell_number;
  logic [COUNT_W-1:0]         point_count;
  logic signed [SUM_W-1:0]    height_sum;
  logic [SQ_W-1:0]            height_square_sum;
  logic [LEVEL_W-1:0]         level;
  logic [COUNT_W-1:0]         least_count;
  logic [COUNT_W-1:0]         most_count;

  modport source (
    output valid, in_grid, cell_number, point_count, height_sum, height_square_sum,
           level, least_count, most_count,
    input  ready
  );

  modport sink (
    input  valid, in_grid, cell_number, point_count, height_sum, height_square_sum,
           level, least_count, most_count,
    output ready
  );

endinterface

// ===== src/pghs_cell_mem.sv =====
module pghs_cell_mem #(
  parameter int DEPTH = pghs_pkg::GRID_SIDE_DEF * pghs_pkg::GRID_SIDE_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  pghs_pkg::cell_t            wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output pghs_pkg::cell_t            rdata
);
  import pghs_pkg::*;

  cell_t mem [DEPTH];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/pghs_level_div.sv =====
module pghs_level_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pghs_pkg::div_req_t req,
  output pghs_pkg::div_rsp_t rsp
);
  import pghs_pkg::*;

  localparam int SW = $clog2(LEVEL_W);

  logic [NUM_W-1:0]   rem_r;
  logic [COUNT_W-1:0] den_r;
  logic [LEVEL_W-1:0] quot_r;
  logic [SW-1:0]      step_r;
  logic               busy_r;
  logic               done_r;
  logic [NUM_W-1:0]   cand;
  logic               ge;

  // quotient is below 256, so one restoring step per quotient bit
  assign cand = NUM_W'(den_r) << step_r;
  assign ge   = rem_r >= cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (step_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      den_r  <= req.den;
      quot_r <= '0;
      step_r <= SW'(LEVEL_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r          <= rem_r - cand;
        quot_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 1'b1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== src/point_grid_height_statistics.sv =====
// Channel  | Dir | Handshake          | Payload
// in_ch    | in  | valid/ready        | kind, x_pos, y_pos, z_pos, read_cell
// out_ch   | out | valid/ready        | in_grid, cell_number, counts, sums, level
// cfg_*    | in  | cfg_we, no stall   | cfg_wdata = cells_per_unit
//
// One item at a time. Add and read pass the read-modify-write and level states, and
// the division state when a level is divided (8-step restoring divider), before the
// output register. Summarize and clear sweep the cell memory, one entry a cycle.
// After reset a pass clearing all GRID_SIDE*GRID_SIDE cells runs before in_ch.ready.
// A stalled output keeps a result in ST_OUT; no new item is taken until it is loaded.
module point_grid_height_statistics #(
  parameter int GRID_SIDE = pghs_pkg::GRID_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pghs_pkg::CFG_W-1:0]  cfg_wdata,
  pghs_in_if.sink                     in_ch,
  pghs_out_if.source                  out_ch
);
  import pghs_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CXW   = $clog2(GRID_SIDE);
  localparam int CMPW  = (AW > CELL_NUM_W ? AW : CELL_NUM_W) + 1;
  localparam int RW    = 13;
  localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] cfg_r;
  kind_t            in_kind;
  kind_t            kind_r;
  logic             item_hit_r;
  logic signed [POS_W-1:0] z_r;
  logic [ZZ_W-1:0]  sq_r;
  logic [AW-1:0]    rd_addr_r;
  logic [AW-1:0]    clr_addr_r;
  logic             clr_item_r;
  logic [COUNT_W-1:0] scan_lo_r, scan_hi_r, scan_lo_nxt, scan_hi_nxt;
  logic [COUNT_W-1:0] min_count_r, max_count_r;

  logic                  res_in_grid_r;
  logic [CELL_NUM_W-1:0] res_cell_r;
  logic [COUNT_W-1:0]    res_count_r;
  logic [SUM_W-1:0]      res_hsum_r;
  logic [SQ_W-1:0]       res_sqsum_r;
  logic [LEVEL_W-1:0]    res_level_r;

  logic                    out_valid_r;
  logic                    out_in_grid_r;
  logic [CELL_NUM_W-1:0]   out_cell_r;
  logic [COUNT_W-1:0]      out_count_r;
  logic signed [SUM_W-1:0] out_hsum_r;
  logic [SQ_W-1:0]         out_sqsum_r;
  logic [LEVEL_W-1:0]      out_level_r;
  logic [COUNT_W-1:0]      out_least_r;
  logic [COUNT_W-1:0]      out_most_r;

  logic          accept;
  logic          out_load;
  logic [RW:0]   xc, yc;
  logic          add_hit;
  logic [AW-1:0] add_cell;
  logic          rd_ok;
  logic [AW-1:0] rd_cell;
  logic signed [ZZ_W-1:0] in_zz;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_wdata;
  cell_t         mem_rdata;
  cell_t         cell_upd;
  cell_t         cell_new;
  logic          do_write;

  logic               lvl_en;
  logic [COUNT_W-1:0] lvl_c;
  logic [COUNT_W-1:0] lvl_d;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // scale, round half away from zero; top bit is "lands in 0..GRID_SIDE-1"
  function automatic logic [RW:0] to_cell(input logic signed [POS_W-1:0] pos,
                                           input logic [CFG_W-1:0] scale);
    logic signed [POS_W+CFG_W:0] p;
    logic [POS_W+CFG_W-1:0]      mag;
    logic [RW-1:0]               r;
    logic                        ok;
    p   = pos * $signed({1'b0, scale});
    mag = p[POS_W+CFG_W] ? (POS_W+CFG_W)'(-p) : (POS_W+CFG_W)'(p);
    r   = RW'((mag + (POS_W+CFG_W)'(128)) >> 8);
    ok  = !(p[POS_W+CFG_W] && (r != '0)) && (r < RW'(GRID_SIDE));
    return {ok, r};
  endfunction

  assign in_kind  = kind_t'(in_ch.kind);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  assign xc       = to_cell(in_ch.x_pos, cfg_r);
  assign yc       = to_cell(in_ch.y_pos, cfg_r);
  assign add_hit  = xc[RW] && yc[RW];
  assign add_cell = AW'(int'(xc[CXW-1:0]) * GRID_SIDE + int'(yc[CXW-1:0]));
  assign rd_ok    = CMPW'(in_ch.read_cell) < CMPW'(CELLS);
  assign rd_cell  = AW'(in_ch.read_cell);
  assign in_zz    = in_ch.z_pos * in_ch.z_pos;

  // update of the entry read in the previous cycle; saturated cells freeze
  always_comb begin
    cell_upd.count = mem_rdata.count + 1'b1;
    cell_upd.hsum  = mem_rdata.hsum + SUM_W'(z_r);
    cell_upd.sqsum = mem_rdata.sqsum + SQ_W'(sq_r);
    do_write = (kind_r == KIND_ADD) && item_hit_r && (mem_rdata.count != COUNT_MAX);
    cell_new = do_write ? cell_upd : mem_rdata;
  end

  always_comb begin
    lvl_en = item_hit_r && (max_count_r > min_count_r);
    if (res_count_r < min_count_r) begin
      lvl_c = min_count_r;
    end else if (res_count_r > max_count_r) begin
      lvl_c = max_count_r;
    end else begin
      lvl_c = res_count_r;
    end
    lvl_d         = lvl_c - min_count_r;
    div_req.start = (state_r == ST_LVL) && lvl_en;
    div_req.num   = (NUM_W'(lvl_d) << 8) - NUM_W'(lvl_d);
    div_req.den   = max_count_r - min_count_r;
  end

  always_comb begin
    if ((rd_addr_r == '0) || (mem_rdata.count < scan_lo_r)) begin
      scan_lo_nxt = mem_rdata.count;
    end else begin
      scan_lo_nxt = scan_lo_r;
    end
    if ((rd_addr_r == '0) || (mem_rdata.count > scan_hi_r)) begin
      scan_hi_nxt = mem_rdata.count;
    end else begin
      scan_hi_nxt = scan_hi_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST) begin
          state_nxt = clr_item_r ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_SUMMARIZE: state_nxt = ST_SCAN;
            KIND_CLEAR:     state_nxt = ST_CLEAR;
            default:        state_nxt = ST_RMW;
          endcase
        end
      end
      ST_RMW:  state_nxt = ST_LVL;
      ST_LVL:  state_nxt = lvl_en ? ST_DIV : ST_OUT;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_SCAN: begin
        if (rd_addr_r == LAST) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready   = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = rd_addr_r;
    mem_wdata     = cell_new;
    mem_raddr     = rd_addr_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        case (in_kind)
          KIND_ADD:  mem_raddr = add_hit ? add_cell : '0;
          KIND_READ: mem_raddr = rd_ok ? rd_cell : '0;
          default:   mem_raddr = '0;
        endcase
      end
      ST_RMW: mem_we = do_write;
      ST_SCAN: begin
        if (rd_addr_r != LAST) begin
          mem_raddr = rd_addr_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cfg_r       <= CFG_RESET;
      clr_addr_r  <= '0;
      clr_item_r  <= 1'b0;
      rd_addr_r   <= '0;
      out_valid_r <= 1'b0;
      min_count_r <= '0;
      max_count_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_addr_r <= mem_raddr;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= (clr_addr_r == LAST) ? '0 : clr_addr_r + 1'b1;
      end
      if (accept) begin
        clr_item_r <= (in_kind == KIND_CLEAR);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == ST_SCAN) && (rd_addr_r == LAST)) begin
        min_count_r <= scan_lo_nxt;
        max_count_r <= scan_hi_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r        <= in_kind;
      item_hit_r    <= ((in_kind == KIND_ADD) && add_hit) ||
                       ((in_kind == KIND_READ) && rd_ok);
      z_r           <= in_ch.z_pos;
      sq_r          <= $unsigned(in_zz);
      res_in_grid_r <= 1'b0;
      res_cell_r    <= '0;
      res_count_r   <= '0;
      res_hsum_r    <= '0;
      res_sqsum_r   <= '0;
      res_level_r   <= '0;
    end
    if ((state_r == ST_RMW) && item_hit_r) begin
      res_in_grid_r <= (kind_r == KIND_ADD);
      res_cell_r    <= CELL_NUM_W'(rd_addr_r);
      res_count_r   <= cell_new.count;
      res_hsum_r    <= cell_new.hsum;
      res_sqsum_r   <= cell_new.sqsum;
    end
    if (state_r == ST_SCAN) begin
      scan_lo_r <= scan_lo_nxt;
      scan_hi_r <= scan_hi_nxt;
    end
    if ((state_r == ST_DIV) && div_rsp.done) begin
      res_level_r <= div_rsp.quot;
    end
    if (out_load) begin
      out_in_grid_r <= res_in_grid_r;
      out_cell_r    <= res_cell_r;
      out_count_r   <= res_count_r;
      out_hsum_r    <= $signed(res_hsum_r);
      out_sqsum_r   <= res_sqsum_r;
      out_level_r   <= res_level_r;
      out_least_r   <= min_count_r;
      out_most_r    <= max_count_r;
    end
  end

  pghs_cell_mem #(
    .DEPTH (CELLS)
  ) u_cell_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pghs_level_div u_level_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_ch.valid             = out_valid_r;
  assign out_ch.in_grid           = out_in_grid_r;
  assign out_ch.cell_number       = out_cell_r;
  assign out_ch.point_count       = out_count_r;
  assign out_ch.height_sum        = out_hsum_r;
  assign out_ch.height_square_sum = out_sqsum_r;
  assign out_ch.level             = out_level_r;
  assign out_ch.least_count       = out_least_r;
  assign out_ch.most_count        = out_most_r;

endmodule

// ===== src/pghs_checker.sv =====
module pghs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_in_grid,
  input logic [pghs_pkg::COUNT_W-1:0]        out_point_count,
  input logic [pghs_pkg::COUNT_W-1:0]        out_least_count,
  input logic [pghs_pkg::COUNT_W-1:0]        out_most_count
);
  import pghs_pkg::*;

  // a result waiting on the sink stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // one item at a time: acceptance always leaves the idle state
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted on two consecutive cycles");

  // a point that landed in the grid has at least itself counted
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_grid |-> out_point_count != '0)
    else $error("in-grid result with zero count");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_least_count <= out_most_count)
    else $error("stored minimum above stored maximum");

endmodule

bind point_grid_height_statistics pghs_checker u_pghs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_in_grid     (out_ch.in_grid),
  .out_point_count (out_ch.point_count),
  .out_least_count (out_ch.least_count),
  .out_most_count  (out_ch.most_count)
);
